// File: hdl/ewia_pkg.sv
`timescale 1ns / 1ps
package ewia_pkg;

    localparam int NUM_WINDOWS = 4;
    localparam int RR_SLOTS    = 32;

    localparam int SLOT_W    = $clog2(RR_SLOTS);
    localparam int FILL_W    = $clog2(RR_SLOTS + 1);
    localparam int IDX_CMP_W = 9;
    localparam int CELL_ID_W = 4;
    localparam int TS_W      = 48;
    localparam int CNT_W     = 32;
    localparam int SEQ_W     = 32;
    localparam int CFG_W     = 32;
    localparam int REQ_W     = 3;
    localparam int WIDX_W    = 2;
    localparam int SIDX_W    = 5;
    localparam int OUT_FILL_W = 6;

    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PEAK    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_GAP     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

    localparam logic [0:0] CFG_STEP     = 1'b0;
    localparam logic [0:0] CFG_DURATION = 1'b1;

    localparam logic [CFG_W-1:0] RESET_STEP_US     = 32'd10000000;
    localparam logic [CFG_W-1:0] RESET_DURATION_US = 32'd30000000;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [TS_W-1:0]   ts;
        logic [SEQ_W-1:0]  seq;
        logic              f_valid;
        logic              f_dropout;
        logic              f_overflow;
        logic              f_clipping;
        logic              f_lead_off;
        logic [WIDX_W-1:0] widx;
        logic [SIDX_W-1:0] sidx;
        logic [TS_W-1:0]   base;
        logic [TS_W-1:0]   res_start;
        logic [CNT_W-1:0]  res_received;
        logic [CNT_W-1:0]  res_dropped;
        logic [CNT_W-1:0]  res_clipping;
        logic [CNT_W-1:0]  res_lead_off;
        logic [CNT_W-1:0]  res_peak;
        logic [FILL_W-1:0] res_fill;
        logic [CNT_W-1:0]  res_interval;
    } item_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [1:0] n);
        logic [CNT_W:0] sum;
        sum = {1'b0, c} + (CNT_W + 1)'(n);
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    function automatic logic [TS_W-1:0] reset_start(input int unsigned idx);
        logic [63:0] prod;
        prod = 64'(idx) * 64'(RESET_STEP_US);
        return prod[TS_W-1:0];
    endfunction

endpackage

// File: hdl/ewia_cell.sv
`timescale 1ns / 1ps
module ewia_cell
    import ewia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CELL_ID_W-1:0] cell_id,
    input  logic [TS_W-1:0]      reset_start,
    input  logic [CFG_W-1:0]     step_us,
    input  logic [CFG_W-1:0]     duration_us,
    input  logic                 take,
    input  item_t                item_i,
    output item_t                item_o
);

    logic [TS_W-1:0]   start_reg,     start_next;
    logic [CNT_W-1:0]  received_reg,  received_next;
    logic [CNT_W-1:0]  dropped_reg,   dropped_next;
    logic [CNT_W-1:0]  clip_reg,      clip_next;
    logic [CNT_W-1:0]  leadoff_reg,   leadoff_next;
    logic [CNT_W-1:0]  peak_reg,      peak_next;
    logic [FILL_W-1:0] fill_reg,      fill_next;
    logic              seq_seen_reg,  seq_seen_next;
    logic [SEQ_W-1:0]  prev_seq_reg,  prev_seq_next;
    logic              peak_seen_reg, peak_seen_next;
    logic [TS_W-1:0]   prev_peak_reg, prev_peak_next;
    logic [CNT_W-1:0]  store_reg [RR_SLOTS];
    item_t             item_reg,      item_next;

    logic                 in_win;
    logic                 seq_break;
    logic                 drop_flag;
    logic                 peak_newer;
    logic                 fill_room;
    logic [TS_W-1:0]      peak_gap;
    logic [CNT_W-1:0]     interval_val;
    logic                 store_we;
    logic [IDX_CMP_W-1:0] sidx_ext;
    logic                 slot_ok;

    always_comb
    begin
        in_win = (item_i.ts >= start_reg) &&
                 ({1'b0, item_i.ts} < ({1'b0, start_reg} + (TS_W + 1)'(duration_us)));
        seq_break    = seq_seen_reg && (item_i.seq != prev_seq_reg + 32'd1);
        drop_flag    = item_i.f_dropout || item_i.f_overflow || seq_break;
        peak_newer   = !peak_seen_reg || (item_i.ts > prev_peak_reg);
        fill_room    = fill_reg < FILL_W'(RR_SLOTS);
        peak_gap     = item_i.ts - prev_peak_reg;
        interval_val = (|peak_gap[TS_W-1:CNT_W]) ? {CNT_W{1'b1}} : peak_gap[CNT_W-1:0];
        sidx_ext     = IDX_CMP_W'(item_i.sidx);
        slot_ok      = (sidx_ext < IDX_CMP_W'(RR_SLOTS)) &&
                       (sidx_ext < IDX_CMP_W'(fill_reg));

        start_next     = start_reg;
        received_next  = received_reg;
        dropped_next   = dropped_reg;
        clip_next      = clip_reg;
        leadoff_next   = leadoff_reg;
        peak_next      = peak_reg;
        fill_next      = fill_reg;
        seq_seen_next  = seq_seen_reg;
        prev_seq_next  = prev_seq_reg;
        peak_seen_next = peak_seen_reg;
        prev_peak_next = prev_peak_reg;
        store_we       = 1'b0;
        item_next      = item_i;

        case (item_i.req)
            REQ_SAMPLE:
            begin
                if (in_win)
                begin
                    received_next = sat_add(received_reg, 2'd1);
                    dropped_next  = sat_add(dropped_reg,
                                            {1'b0, drop_flag} + {1'b0, !item_i.f_valid});
                    prev_seq_next = item_i.seq;
                    seq_seen_next = 1'b1;
                    if (drop_flag || item_i.f_lead_off)
                    begin
                        peak_seen_next = 1'b0;
                    end
                    if (item_i.f_clipping)
                    begin
                        clip_next = sat_add(clip_reg, 2'd1);
                    end
                    if (item_i.f_lead_off)
                    begin
                        leadoff_next = sat_add(leadoff_reg, 2'd1);
                    end
                end
            end
            REQ_PEAK:
            begin
                if (in_win && peak_newer)
                begin
                    peak_next = sat_add(peak_reg, 2'd1);
                    if (peak_seen_reg)
                    begin
                        if (fill_room)
                        begin
                            store_we  = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                        else
                        begin
                            dropped_next = sat_add(dropped_reg, 2'd1);
                        end
                    end
                    prev_peak_next = item_i.ts;
                    peak_seen_next = 1'b1;
                end
            end
            REQ_GAP:
            begin
                if (in_win)
                begin
                    peak_seen_next = 1'b0;
                    dropped_next   = sat_add(dropped_reg, 2'd1);
                end
            end
            REQ_RESTART:
            begin
                start_next     = item_i.base;
                received_next  = '0;
                dropped_next   = '0;
                clip_next      = '0;
                leadoff_next   = '0;
                peak_next      = '0;
                fill_next      = '0;
                seq_seen_next  = 1'b0;
                prev_seq_next  = '0;
                peak_seen_next = 1'b0;
                prev_peak_next = '0;
                item_next.base = item_i.base + TS_W'(step_us);
            end
            REQ_READ:
            begin
                if (CELL_ID_W'(item_i.widx) == cell_id)
                begin
                    item_next.res_start    = start_reg;
                    item_next.res_received = received_reg;
                    item_next.res_dropped  = dropped_reg;
                    item_next.res_clipping = clip_reg;
                    item_next.res_lead_off = leadoff_reg;
                    item_next.res_peak     = peak_reg;
                    item_next.res_fill     = fill_reg;
                    item_next.res_interval = slot_ok ? store_reg[sidx_ext[SLOT_W-1:0]] : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= reset_start;
            received_reg  <= '0;
            dropped_reg   <= '0;
            clip_reg      <= '0;
            leadoff_reg   <= '0;
            peak_reg      <= '0;
            fill_reg      <= '0;
            seq_seen_reg  <= 1'b0;
            prev_seq_reg  <= '0;
            peak_seen_reg <= 1'b0;
            prev_peak_reg <= '0;
        end
        else if (take)
        begin
            start_reg     <= start_next;
            received_reg  <= received_next;
            dropped_reg   <= dropped_next;
            clip_reg      <= clip_next;
            leadoff_reg   <= leadoff_next;
            peak_reg      <= peak_next;
            fill_reg      <= fill_next;
            seq_seen_reg  <= seq_seen_next;
            prev_seq_reg  <= prev_seq_next;
            peak_seen_reg <= peak_seen_next;
            prev_peak_reg <= prev_peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
            if (store_we)
            begin
                store_reg[fill_reg[SLOT_W-1:0]] <= interval_val;
            end
        end
    end

    assign item_o = item_reg;

endmodule

// File: hdl/ecg_window_integrity_accumulator.sv
`timescale 1ns / 1ps
// Every transaction on the input channel is registered at entry and then passes down a row of
// NUM_WINDOWS window cells, one cell per cycle while the row moves, so the block takes one item
// in every cycle unless a stalled read result at the output has filled the row; a read result
// appears on the output after the entry register and every cell of the row. Samples, peaks and
// gaps update each window whose span holds the timestamp, a restart re-bases all windows as it
// passes, and only reads produce a result transaction. While a read result at the output is
// stalled the row keeps taking items until its empty stages are full.
module ecg_window_integrity_accumulator
    import ewia_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [TS_W-1:0]   event_time_us,
    input  logic [SEQ_W-1:0]  seq_number,
    input  logic              flag_valid,
    input  logic              flag_dropout,
    input  logic              flag_overflow,
    input  logic              flag_clipping,
    input  logic              flag_lead_off,
    input  logic [WIDX_W-1:0] window_index,
    input  logic [SIDX_W-1:0] slot_index,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [TS_W-1:0]   window_start_us,
    output logic [CNT_W-1:0]  received_count,
    output logic [CNT_W-1:0]  dropped_count,
    output logic [CNT_W-1:0]  clip_total,
    output logic [CNT_W-1:0]  leadoff_total,
    output logic [CNT_W-1:0]  peak_total,
    output logic [OUT_FILL_W-1:0] rr_count,
    output logic [CNT_W-1:0]  interval_us
);

    logic [CFG_W-1:0]     step_reg;
    logic [CFG_W-1:0]     duration_reg;
    logic [NUM_WINDOWS:0] valid_reg;
    logic [NUM_WINDOWS:0] ready;
    item_t                in_item_reg;
    item_t                chain [NUM_WINDOWS+1];
    item_t                last_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= RESET_STEP_US;
            duration_reg <= RESET_DURATION_US;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP:     step_reg     <= cfg_data;
                CFG_DURATION: duration_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign last_item = chain[NUM_WINDOWS];

    always_comb
    begin
        ready[NUM_WINDOWS] = !(valid_reg[NUM_WINDOWS] && (last_item.req == REQ_READ) &&
                               out_stall);
        for (int k = NUM_WINDOWS - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign in_stall = !ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k <= NUM_WINDOWS; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready[0])
        begin
            in_item_reg.req          <= req_type;
            in_item_reg.ts           <= event_time_us;
            in_item_reg.seq          <= seq_number;
            in_item_reg.f_valid      <= flag_valid;
            in_item_reg.f_dropout    <= flag_dropout;
            in_item_reg.f_overflow   <= flag_overflow;
            in_item_reg.f_clipping   <= flag_clipping;
            in_item_reg.f_lead_off   <= flag_lead_off;
            in_item_reg.widx         <= window_index;
            in_item_reg.sidx         <= slot_index;
            in_item_reg.base         <= event_time_us;
            in_item_reg.res_start    <= '0;
            in_item_reg.res_received <= '0;
            in_item_reg.res_dropped  <= '0;
            in_item_reg.res_clipping <= '0;
            in_item_reg.res_lead_off <= '0;
            in_item_reg.res_peak     <= '0;
            in_item_reg.res_fill     <= '0;
            in_item_reg.res_interval <= '0;
        end
    end

    assign chain[0] = in_item_reg;

    for (genvar w = 0; w < NUM_WINDOWS; w++)
    begin : g_cell
        localparam logic [TS_W-1:0] CellResetStart = reset_start(w);

        ewia_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_id     (CELL_ID_W'(w)),
            .reset_start (CellResetStart),
            .step_us     (step_reg),
            .duration_us (duration_reg),
            .take        (valid_reg[w] && ready[w+1]),
            .item_i      (chain[w]),
            .item_o      (chain[w+1])
        );
    end

    assign out_valid       = valid_reg[NUM_WINDOWS] && (last_item.req == REQ_READ);
    assign window_start_us = last_item.res_start;
    assign received_count  = last_item.res_received;
    assign dropped_count   = last_item.res_dropped;
    assign clip_total      = last_item.res_clipping;
    assign leadoff_total   = last_item.res_lead_off;
    assign peak_total      = last_item.res_peak;
    assign rr_count        = OUT_FILL_W'(last_item.res_fill);
    assign interval_us     = last_item.res_interval;

    a_entry_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !ready[1] |=> valid_reg[0] && $stable(in_item_reg))
        else $error("Entry stage lost or altered a blocked item.");

    a_entry_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("Accepted input transaction did not enter the cell row.");

    a_unused_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (IDX_CMP_W'(last_item.sidx) >= IDX_CMP_W'(last_item.res_fill))
        |-> interval_us == '0)
        else $error("Interval reported for a slot that holds no interval.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> IDX_CMP_W'(last_item.res_fill) <= IDX_CMP_W'(RR_SLOTS))
        else $error("Interval fill count exceeds the number of slots.");

endmodule
